@@ sv/whl_pkg.sv @@
// Shared types and constants for the weighted code histogram lookup table.
package whl_pkg;

	localparam int LUT_BINS_DEF    = 256;
	localparam int MAX_SAMPLES_DEF = 65536;

	localparam int CMD_W     = 2;
	localparam int CODE_W    = 8;
	localparam int WEIGHT_W  = 32;
	localparam int SUM_W     = 40;
	localparam int LUT_W     = 16;
	localparam int NUM_POS_W = 16;
	localparam int DIV_STEPS = LUT_W;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_NUM_POSITIVES = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_READ  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [CODE_W-1:0]   code;
		logic [WEIGHT_W-1:0] weight;
	} sample_t;

	typedef struct packed {
		logic signed [LUT_W-1:0] lut_value;
		logic                    bin_empty;
	} result_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ sv/whl_sum_ram.sv @@
// Bin sum memory: one write port, one registered read port, {plus, minus} per entry.
module whl_sum_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [AW-1:0]                 waddr,
	input  logic [2*whl_pkg::SUM_W-1:0]   wdata,
	input  logic                          re,
	input  logic [AW-1:0]                 raddr,
	output logic [2*whl_pkg::SUM_W-1:0]   rdata
);
	import whl_pkg::*;

	logic [2*SUM_W-1:0] mem [DEPTH];
	logic [2*SUM_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/whl_div.sv @@
// Ratio unit: (plus-minus)/(plus+minus) in Q1.15, one quotient bit per cycle.
module whl_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [whl_pkg::SUM_W-1:0]   plus,
	input  logic [whl_pkg::SUM_W-1:0]   minus,
	input  logic                        take,
	output whl_pkg::div_stat_t          stat,
	output whl_pkg::result_t            res
);
	import whl_pkg::*;

	div_state_t state_q, state_d;

	logic [SUM_W+1:0]     rem_q;
	logic [SUM_W:0]       den_q;
	logic [LUT_W-1:0]     quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 neg_q;
	logic                 empty_q;

	logic [SUM_W:0]   total;
	logic [SUM_W-1:0] mag;
	logic             ge;
	logic [SUM_W+1:0] rem_next;

	assign total    = {1'b0, plus} + {1'b0, minus};
	assign mag      = (plus >= minus) ? (plus - minus) : (minus - plus);
	assign ge       = rem_q >= {1'b0, den_q};
	assign rem_next = ge ? (rem_q - {1'b0, den_q}) : rem_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					state_d = (total == '0) ? DIV_DONE : DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (cnt_q == '0) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: begin
				if (take) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		stat.busy = 1'b0;
		stat.done = 1'b0;
		case (state_q)
			DIV_IDLE: begin
				stat.busy = 1'b0;
			end
			DIV_RUN: begin
				stat.busy = 1'b1;
			end
			DIV_DONE: begin
				stat.busy = 1'b1;
				stat.done = 1'b1;
			end
			default: stat.busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DIV_IDLE && start) begin
			rem_q   <= {2'b00, mag};
			den_q   <= total;
			quo_q   <= '0;
			cnt_q   <= DIV_CNT_W'(DIV_STEPS - 1);
			neg_q   <= plus < minus;
			empty_q <= total == '0;
		end else if (state_q == DIV_RUN) begin
			quo_q <= {quo_q[LUT_W-2:0], ge};
			rem_q <= {rem_next[SUM_W:0], 1'b0};
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_comb begin
		res.bin_empty = empty_q;
		if (neg_q) begin
			res.lut_value = -quo_q;
		end else if (quo_q[LUT_W-1]) begin
			res.lut_value = {1'b0, {(LUT_W-1){1'b1}}};
		end else begin
			res.lut_value = quo_q;
		end
	end

endmodule

@@ sv/weighted_code_histogram_lut.sv @@
// Top level of the weighted code histogram lookup table.
//
// Usage: the sample channel (sample_valid/sample_ready/sample) carries clear,
// add and read commands; the result channel (result_valid/result_ready/result)
// returns one transfer per read. num_positives is written over the APB port
// at byte address 0 while the block is idle.
// Adds and clears: one per cycle while input is not held off by a read. An add
// is a read-modify-write on the sum memory with forwarding from the write of the
// previous cycle; a clear resets the per-bin valid bits. Neither leaves a result.
// Reads: the bin is fetched through the registered read port of the memory,
// then the ratio unit computes the quotient bit by bit, 16 bits in all, and
// skips the division for an empty bin; the result then goes to the output
// register. Input is held off from the read transfer until the ratio unit hands
// its result to the output register.
// Reset clears the per-bin valid bits, the sample counter and num_positives;
// no memory sweep is needed. A stalled receiver holds the output register;
// adds and clears still flow until a further read is taken, whose result then
// waits in the ratio unit and holds off input until the output register empties.
module weighted_code_histogram_lut #(
	parameter int LUT_BINS    = whl_pkg::LUT_BINS_DEF,
	parameter int MAX_SAMPLES = whl_pkg::MAX_SAMPLES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_ready,
	input  whl_pkg::sample_t                sample,
	output logic                            result_valid,
	input  logic                            result_ready,
	output whl_pkg::result_t                result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [whl_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [whl_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [whl_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready
);
	import whl_pkg::*;

	localparam int AW = $clog2(LUT_BINS);
	localparam int CW = $clog2(MAX_SAMPLES);
	localparam int XW = AW + CODE_W;

	logic [NUM_POS_W-1:0] num_pos_q;
	logic [CW-1:0]        cnt_q;

	logic          accept;
	logic          is_clear;
	logic          is_add;
	logic          is_read;
	logic          in_range;
	logic          positive;
	logic [XW-1:0] code_x;

	logic                add_s1;
	logic                rd_s1;
	logic [AW-1:0]       addr_s1;
	logic                in_range_s1;
	logic                pos_s1;
	logic [WEIGHT_W-1:0] weight_s1;

	logic [LUT_BINS-1:0] bin_valid_q;
	logic                fwd_v_q;
	logic [AW-1:0]       fwd_addr_q;
	logic [2*SUM_W-1:0]  fwd_data_q;

	logic [2*SUM_W-1:0] rdata;
	logic [2*SUM_W-1:0] old_sums;
	logic [SUM_W-1:0]   plus_old;
	logic [SUM_W-1:0]   minus_old;
	logic [SUM_W-1:0]   addend;
	logic [SUM_W:0]     sum_wide;
	logic [SUM_W-1:0]   sum_sat;
	logic [2*SUM_W-1:0] new_sums;
	logic               wr_en;

	div_stat_t div_stat;
	result_t   div_res;
	logic      div_take;
	logic      res_v_q;
	result_t   res_q;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1] == REG_NUM_POSITIVES) ?
		APB_DATA_W'(num_pos_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_pos_q <= '0;
		end else if (psel && penable && pwrite && pready &&
				paddr[APB_ADDR_W-1] == REG_NUM_POSITIVES) begin
			num_pos_q <= pwdata[NUM_POS_W-1:0];
		end
	end

	// Input decode
	assign sample_ready = !rd_s1 && !div_stat.busy;
	assign accept       = sample_valid && sample_ready;
	assign is_clear     = sample.command == CMD_CLEAR;
	assign is_add       = sample.command == CMD_ADD;
	assign is_read      = sample.command == CMD_READ;
	assign code_x       = XW'(sample.code);
	assign in_range     = 32'(sample.code) < LUT_BINS;
	assign positive     = 32'(cnt_q) < 32'(num_pos_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept && is_clear) begin
			cnt_q <= '0;
		end else if (accept && is_add && cnt_q < CW'(MAX_SAMPLES - 1)) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_s1 <= 1'b0;
			rd_s1  <= 1'b0;
		end else begin
			add_s1 <= accept && is_add;
			rd_s1  <= accept && is_read;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1     <= code_x[AW-1:0];
			in_range_s1 <= in_range;
			pos_s1      <= positive;
			weight_s1   <= sample.weight;
		end
	end

	whl_sum_ram #(
		.DEPTH(LUT_BINS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr_s1),
		.wdata(new_sums),
		.re   (accept),
		.raddr(code_x[AW-1:0]),
		.rdata(rdata)
	);

	// Read-modify-write stage
	always_comb begin
		if (fwd_v_q && fwd_addr_q == addr_s1) begin
			old_sums = fwd_data_q;
		end else if (in_range_s1 && bin_valid_q[addr_s1]) begin
			old_sums = rdata;
		end else begin
			old_sums = '0;
		end
	end

	assign plus_old  = in_range_s1 ? old_sums[2*SUM_W-1:SUM_W] : '0;
	assign minus_old = in_range_s1 ? old_sums[SUM_W-1:0] : '0;
	assign addend    = pos_s1 ? plus_old : minus_old;
	assign sum_wide  = {1'b0, addend} + (SUM_W+1)'(weight_s1);
	assign sum_sat   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
	assign new_sums  = pos_s1 ? {sum_sat, minus_old} : {plus_old, sum_sat};
	assign wr_en     = add_s1 && in_range_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_q <= '0;
			fwd_v_q     <= 1'b0;
		end else begin
			if (accept && is_clear) begin
				bin_valid_q <= '0;
			end else if (wr_en) begin
				bin_valid_q[addr_s1] <= 1'b1;
			end
			fwd_v_q <= wr_en && !(accept && is_clear);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_sums;
		end
	end

	// Ratio unit and output register
	assign div_take = div_stat.done && (!res_v_q || result_ready);

	whl_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (rd_s1),
		.plus  (plus_old),
		.minus (minus_old),
		.take  (div_take),
		.stat  (div_stat),
		.res   (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else if (div_take) begin
			res_v_q <= 1'b1;
		end else if (result_ready) begin
			res_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_take) begin
			res_q <= div_res;
		end
	end

	assign result_valid = res_v_q;
	assign result       = res_q;

endmodule
